@@ rtl/twacs_pkg.sv @@
// Package for the three-way alignment column scorer.
// Widths, gap codes, register indexes and shared structs; no dependencies.
package twacs_pkg;

    localparam int CHAR_WIDTH     = 8;   // low character bits that are compared
    localparam int CHAR_IN_WIDTH  = 8;   // character field width on the channel
    localparam int COST_WIDTH     = 32;  // running total width (16..64)
    localparam int OUT_COST_WIDTH = 32;  // reported cost width
    localparam int CFG_WIDTH      = 8;
    localparam int CFG_IDX_WIDTH  = 2;
    // opens (3 x 255) plus extends (3 x 255) stays below 2^(CFG_WIDTH+3)
    localparam int INC_WIDTH      = CFG_WIDTH + 3;

    typedef enum logic [1:0] {
        CODE_MATCH   = 2'd0,
        CODE_DELETE  = 2'd1,
        CODE_INSERT  = 2'd2,
        CODE_INVALID = 2'd3
    } t_code;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_MISMATCH   = 2'd0,
        REG_GAP_OPEN   = 2'd1,
        REG_GAP_EXTEND = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] mismatch_cost;
        logic [CFG_WIDTH-1:0] gap_open_cost;
        logic [CFG_WIDTH-1:0] gap_extend_cost;
    } t_cost_cfg;

    typedef struct packed {
        t_code                    code_a;
        t_code                    code_b;
        t_code                    code_c;
        logic [CHAR_IN_WIDTH-1:0] char_a;
        logic [CHAR_IN_WIDTH-1:0] char_b;
        logic [CHAR_IN_WIDTH-1:0] char_c;
        logic                     last_column;
    } t_column;

    typedef struct packed {
        logic [OUT_COST_WIDTH-1:0] running_cost;
        logic                      final_total;
        logic                      bad_column;
    } t_result;

endpackage

@@ rtl/twacs_if.sv @@
// Channel interfaces of the column scorer: column in, result out, register writes.
// Depends on twacs_pkg.
interface twacs_col_if;
    import twacs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               code_a;
    logic [1:0]               code_b;
    logic [1:0]               code_c;
    logic [CHAR_IN_WIDTH-1:0] char_a;
    logic [CHAR_IN_WIDTH-1:0] char_b;
    logic [CHAR_IN_WIDTH-1:0] char_c;
    logic                     last_column;

    modport source (output valid, code_a, code_b, code_c, char_a, char_b, char_c,
                    last_column, input ready);
    modport sink   (input valid, code_a, code_b, code_c, char_a, char_b, char_c,
                    last_column, output ready);
endinterface

interface twacs_res_if;
    import twacs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [OUT_COST_WIDTH-1:0] running_cost;
    logic                      final_total;
    logic                      bad_column;

    modport source (output valid, running_cost, final_total, bad_column, input ready);
    modport sink   (input valid, running_cost, final_total, bad_column, output ready);
endinterface

interface twacs_cfg_if;
    import twacs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [CFG_WIDTH-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/twacs_cfg.sv @@
// Cost register file of the column scorer: three 8-bit costs with reset values.
// Depends on twacs_pkg and twacs_cfg_if.
module twacs_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    twacs_cfg_if.sink            i_cfg,
    output twacs_pkg::t_cost_cfg o_cost_cfg
);
    import twacs_pkg::*;

    t_cost_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cost_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mismatch_cost   <= CFG_WIDTH'(1);
            r_cfg.gap_open_cost   <= CFG_WIDTH'(3);
            r_cfg.gap_extend_cost <= CFG_WIDTH'(1);
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_MISMATCH:   r_cfg.mismatch_cost   <= i_cfg.data;
                REG_GAP_OPEN:   r_cfg.gap_open_cost   <= i_cfg.data;
                REG_GAP_EXTEND: r_cfg.gap_extend_cost <= i_cfg.data;
                default: ;  // writes past the last register are dropped
            endcase
        end
    end

endmodule

@@ rtl/twacs_core.sv @@
// Column scoring pipeline: input register, cost increment and saturating
// accumulate, result register. Depends on twacs_pkg and the channel interfaces.
module twacs_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  twacs_pkg::t_cost_cfg i_cost_cfg,
    twacs_col_if.sink            i_col,
    twacs_res_if.source          o_res
);
    import twacs_pkg::*;

    t_column               r_col;
    logic                  r_col_valid;
    t_code                 r_prev_a, r_prev_b, r_prev_c;
    logic [COST_WIDTH-1:0] r_cost;
    t_result               r_res;
    logic                  r_res_valid;

    logic                  adv;
    logic                  ma, mb, mc, da, db, dc, ia, ib, ic;
    logic                  bad;
    logic                  d_ab, d_bc, d_ac;
    logic [1:0]            diffs;
    logic [INC_WIDTH-1:0]  open_sum, ext_sum, mm_sum, inc;
    logic [COST_WIDTH:0]   sum;
    logic [COST_WIDTH-1:0] n_cost_out;
    logic [63:0]           cost_wide;
    t_result               n_res;

    assign adv         = !r_res_valid || o_res.ready;
    assign i_col.ready = !r_col_valid || adv;

    always_comb begin
        ma = (r_col.code_a == CODE_MATCH);
        mb = (r_col.code_b == CODE_MATCH);
        mc = (r_col.code_c == CODE_MATCH);
        da = (r_col.code_a == CODE_DELETE);
        db = (r_col.code_b == CODE_DELETE);
        dc = (r_col.code_c == CODE_DELETE);
        ia = (r_col.code_a == CODE_INSERT);
        ib = (r_col.code_b == CODE_INSERT);
        ic = (r_col.code_c == CODE_INSERT);
        bad = (r_col.code_a == CODE_INVALID) || (r_col.code_b == CODE_INVALID)
            || (r_col.code_c == CODE_INVALID) || !(ma || mb || mc)
            || (ia && ib) || (ia && ic) || (ib && ic);

        // gap opens: a non-match code that changed from the previous column
        open_sum = ((!ma && r_col.code_a != r_prev_a) ?
                        INC_WIDTH'(i_cost_cfg.gap_open_cost) : '0)
                 + ((!mb && r_col.code_b != r_prev_b) ?
                        INC_WIDTH'(i_cost_cfg.gap_open_cost) : '0)
                 + ((!mc && r_col.code_c != r_prev_c) ?
                        INC_WIDTH'(i_cost_cfg.gap_open_cost) : '0);

        d_ab = r_col.char_a[CHAR_WIDTH-1:0] != r_col.char_b[CHAR_WIDTH-1:0];
        d_bc = r_col.char_b[CHAR_WIDTH-1:0] != r_col.char_c[CHAR_WIDTH-1:0];
        d_ac = r_col.char_a[CHAR_WIDTH-1:0] != r_col.char_c[CHAR_WIDTH-1:0];

        unique case ({ma, mb, mc})
            3'b111: begin
                // x-y-x pattern costs one mismatch, not two
                if (d_ab && !d_ac) begin
                    diffs = 2'd1;
                end else begin
                    diffs = {1'b0, d_ab} + {1'b0, d_bc};
                end
            end
            3'b110:  diffs = {1'b0, d_ab};
            3'b101:  diffs = {1'b0, d_ac};
            3'b011:  diffs = {1'b0, d_bc};
            default: diffs = 2'd0;
        endcase

        unique case (diffs)
            2'd2:    mm_sum = INC_WIDTH'(i_cost_cfg.mismatch_cost) << 1;
            2'd1:    mm_sum = INC_WIDTH'(i_cost_cfg.mismatch_cost);
            default: mm_sum = '0;
        endcase

        if (ia || ib || ic) begin
            ext_sum = INC_WIDTH'(i_cost_cfg.gap_extend_cost);
            inc     = open_sum + ext_sum;
        end else begin
            ext_sum = (da ? INC_WIDTH'(i_cost_cfg.gap_extend_cost) : '0)
                    + (db ? INC_WIDTH'(i_cost_cfg.gap_extend_cost) : '0)
                    + (dc ? INC_WIDTH'(i_cost_cfg.gap_extend_cost) : '0);
            inc     = open_sum + ext_sum + mm_sum;
        end

        sum = {1'b0, r_cost} + (COST_WIDTH + 1)'(inc);
        if (bad) begin
            n_cost_out = r_cost;
        end else if (sum[COST_WIDTH]) begin
            n_cost_out = '1;
        end else begin
            n_cost_out = sum[COST_WIDTH-1:0];
        end

        cost_wide = 64'(n_cost_out);
        n_res.running_cost = (cost_wide > 64'(OUT_COST_WIDTH'('1))) ?
                             '1 : OUT_COST_WIDTH'(cost_wide);
        n_res.final_total  = r_col.last_column;
        n_res.bad_column   = bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_valid <= 1'b0;
            r_res_valid <= 1'b0;
            r_prev_a    <= CODE_MATCH;
            r_prev_b    <= CODE_MATCH;
            r_prev_c    <= CODE_MATCH;
            r_cost      <= '0;
        end else begin
            if (i_col.ready) begin
                r_col_valid <= i_col.valid;
            end
            if (adv) begin
                r_res_valid <= r_col_valid;
                if (r_col_valid) begin
                    if (r_col.last_column) begin
                        r_prev_a <= CODE_MATCH;
                        r_prev_b <= CODE_MATCH;
                        r_prev_c <= CODE_MATCH;
                        r_cost   <= '0;
                    end else begin
                        if (!bad) begin
                            r_prev_a <= r_col.code_a;
                            r_prev_b <= r_col.code_b;
                            r_prev_c <= r_col.code_c;
                        end
                        r_cost <= n_cost_out;
                    end
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_col.ready && i_col.valid) begin
            r_col.code_a      <= t_code'(i_col.code_a);
            r_col.code_b      <= t_code'(i_col.code_b);
            r_col.code_c      <= t_code'(i_col.code_c);
            r_col.char_a      <= i_col.char_a;
            r_col.char_b      <= i_col.char_b;
            r_col.char_c      <= i_col.char_c;
            r_col.last_column <= i_col.last_column;
        end
        if (adv && r_col_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.running_cost = r_res.running_cost;
    assign o_res.final_total  = r_res.final_total;
    assign o_res.bad_column   = r_res.bad_column;

    // last column returns the scorer to its reset state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_col_valid && r_col.last_column |=>
            r_cost == '0 && r_prev_a == CODE_MATCH && r_prev_b == CODE_MATCH
            && r_prev_c == CODE_MATCH)
        else $error("state not cleared after last column");

    // a rejected column that is not a last column changes neither the total nor the previous codes
    a_bad_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_col_valid && bad && !r_col.last_column |=>
            $stable(r_cost) && $stable(r_prev_a) && $stable(r_prev_b)
            && $stable(r_prev_c))
        else $error("rejected column altered scoring state");

    // within one alignment the total never goes down
    a_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_col_valid && !r_col.last_column |=> r_cost >= $past(r_cost))
        else $error("running cost decreased");

    // a held column is not overwritten while the result side stalls
    a_col_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_valid && !adv |=> r_col_valid && $stable(r_col))
        else $error("pending column lost");

endmodule

@@ rtl/three_way_alignment_column_scorer_top.sv @@
// Top level of the three-way alignment column scorer.
// Depends on twacs_pkg, the channel interfaces, twacs_cfg and twacs_core.
//
// Usage:
//   i_col  : one alignment column per transfer (three gap codes, three
//            characters, last_column flag).
//   o_res  : one result per column: running_cost, final_total, bad_column.
//   i_cfg  : register writes, index 0 mismatch, 1 gap open, 2 gap extend;
//            always ready, writes to index 3 are dropped. Write only while idle.
// Path: an accepted column sits in the input register, moves to the result
//   register (o_res.valid high) when that is free, then transfers out on o_res.ready.
// Throughput: one column per cycle while o_res is taken. The per-column work is one short
//   increment and a saturating add into the running total, all combinational
//   between the input and result registers.
// Stall: when o_res is not taken the result register holds, one more column
//   may still sit in the input register, and i_col.ready drops after that.
// Reset (i_rst_n low, synchronous): both registers empty, running total zero,
//   previous codes all match, costs back to 1 / 3 / 1.
// A column flagged bad adds nothing and reports the unchanged total; after a
//   last column the total and previous codes return to their reset values.
module three_way_alignment_column_scorer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    twacs_col_if.sink   i_col,
    twacs_cfg_if.sink   i_cfg,
    twacs_res_if.source o_res
);
    import twacs_pkg::*;

    t_cost_cfg cost_cfg;

    twacs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .o_cost_cfg (cost_cfg)
    );

    twacs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cost_cfg (cost_cfg),
        .i_col      (i_col),
        .o_res      (o_res)
    );

endmodule

@@ tb/tb.sv @@
// Testbench for three_way_alignment_column_scorer_top: directed columns, register
// extremes and random alignments, checked against an in-bench cost predictor.
// Depends on twacs_pkg, the channel interfaces in rtl/twacs_if.sv and the RTL.
module tb;
    import twacs_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    twacs_col_if col_ch ();
    twacs_cfg_if cfg_ch ();
    twacs_res_if res_ch ();

    three_way_alignment_column_scorer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_col   (col_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: costs, codes of the last scored column, running total.
    t_cost_cfg             costs;
    t_code                 prior_codes [3];
    logic [COST_WIDTH-1:0] path_cost;

    // Scores still owed by the block, oldest first.
    t_result pending_scores [$];
    t_result head;

    int  fail_count  = 0;
    int  cols_sent   = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  gaps_on     = 1'b0;   // sender waits a random count before each column
    bit  stall_on    = 1'b0;   // sink holds ready low a random count after each result

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d scores still pending", $time, pending_scores.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void clear_alignment();
        foreach (prior_codes[s]) prior_codes[s] = CODE_MATCH;
        path_cost = '0;
    endfunction

    // Cost of one column; updates the alignment state the way the block must.
    function automatic t_result score_column(input t_column c);
        t_code                 codes [3];
        logic [CHAR_WIDTH-1:0] chars [3];
        logic [CHAR_WIDTH-1:0] hits  [3];
        int                    n_hit, n_del, n_ins, n_inv, diffs;
        logic [COST_WIDTH-1:0] step;
        logic [COST_WIDTH-1:0] ceiling;
        bit                    rejected;
        t_result               r;
        codes[0] = c.code_a;
        codes[1] = c.code_b;
        codes[2] = c.code_c;
        chars[0] = c.char_a[CHAR_WIDTH-1:0];
        chars[1] = c.char_b[CHAR_WIDTH-1:0];
        chars[2] = c.char_c[CHAR_WIDTH-1:0];
        n_hit = 0;
        n_del = 0;
        n_ins = 0;
        n_inv = 0;
        diffs = 0;
        step = '0;
        ceiling = '1;
        for (int s = 0; s < 3; s++) begin
            case (codes[s])
                CODE_MATCH: begin
                    hits[n_hit] = chars[s];
                    n_hit++;
                end
                CODE_DELETE: n_del++;
                CODE_INSERT: n_ins++;
                default:     n_inv++;
            endcase
        end
        rejected = (n_inv != 0) || (n_hit == 0) || (n_ins > 1);
        if (!rejected) begin
            for (int s = 0; s < 3; s++) begin
                if (codes[s] != CODE_MATCH && codes[s] != prior_codes[s])
                    step += COST_WIDTH'(costs.gap_open_cost);
                prior_codes[s] = codes[s];
            end
            if (n_ins == 1) begin
                // insert column: one extend, characters not charged
                step += COST_WIDTH'(costs.gap_extend_cost);
            end else begin
                step += COST_WIDTH'(costs.gap_extend_cost * n_del);
                for (int k = 1; k < n_hit; k++)
                    if (hits[k-1] != hits[k]) diffs++;
                // x-y-x over three matches is charged once, not twice
                if (n_hit == 3 && hits[0] == hits[2] && hits[0] != hits[1]) diffs--;
                step += COST_WIDTH'(costs.mismatch_cost * diffs);
            end
            if (path_cost > ceiling - step) path_cost = ceiling;
            else path_cost += step;
        end
        if (COST_WIDTH > OUT_COST_WIDTH && (path_cost >> OUT_COST_WIDTH) != 0)
            r.running_cost = '1;
        else
            r.running_cost = OUT_COST_WIDTH'(path_cost);
        r.final_total = c.last_column;
        r.bad_column  = rejected;
        if (c.last_column) clear_alignment();
        return r;
    endfunction

    // Result side: compare every transfer with the oldest pending score.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_scores.size() == 0) begin
                $display("%0t: unexpected result: cost %0d final %0b bad %0b", $time,
                         res_ch.running_cost, res_ch.final_total, res_ch.bad_column);
                fail_count++;
            end else begin
                head = pending_scores.pop_front();
                if (res_ch.running_cost !== head.running_cost) begin
                    $display("%0t: running_cost expected %0d actual %0d", $time,
                             head.running_cost, res_ch.running_cost);
                    fail_count++;
                end
                if (res_ch.final_total !== head.final_total) begin
                    $display("%0t: final_total expected %0b actual %0b", $time,
                             head.final_total, res_ch.final_total);
                    fail_count++;
                end
                if (res_ch.bad_column !== head.bad_column) begin
                    $display("%0t: bad_column expected %0b actual %0b", $time,
                             head.bad_column, res_ch.bad_column);
                    fail_count++;
                end
            end
            stall_left = stall_on ? $urandom_range(0, 15) : 0;
        end
    end

    // Sink ready changes on the falling edge only.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready = 1'b0;
            stall_left--;
        end else begin
            res_ch.ready = 1'b1;
        end
    end

    // One column transfer; the score is predicted at the accepting edge.
    task automatic send_column(input t_column c);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            col_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        col_ch.code_a      = c.code_a;
        col_ch.code_b      = c.code_b;
        col_ch.code_c      = c.code_c;
        col_ch.char_a      = c.char_a;
        col_ch.char_b      = c.char_b;
        col_ch.char_c      = c.char_c;
        col_ch.last_column = c.last_column;
        col_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!col_ch.ready);
        pending_scores.push_back(score_column(c));
        cols_sent++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_WIDTH-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_MISMATCH:   costs.mismatch_cost   = value;
            REG_GAP_OPEN:   costs.gap_open_cost   = value;
            REG_GAP_EXTEND: costs.gap_extend_cost = value;
            default: ;  // unused index is dropped by the block
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Stop sending and wait until every pending score has come back.
    task automatic wait_for_scores();
        @(negedge i_clk);
        col_ch.valid = 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_column column_of(input t_code a, input t_code b, input t_code c,
                                          input logic [7:0] ca, input logic [7:0] cb,
                                          input logic [7:0] cc, input bit last);
        t_column col;
        col.code_a      = a;
        col.code_b      = b;
        col.code_c      = c;
        col.char_a      = CHAR_IN_WIDTH'(ca);
        col.char_b      = CHAR_IN_WIDTH'(cb);
        col.char_c      = CHAR_IN_WIDTH'(cc);
        col.last_column = last;
        return col;
    endfunction

    // Well-formed column: some match, at most one insert, no invalid code.
    // Gap runs are kept going often so extends follow opens.
    function automatic t_column legal_column(input bit last, input t_column prev);
        t_column col;
        int      n_hit, n_ins;
        col = prev;
        if ($urandom_range(0, 2) != 0 || col.code_a == CODE_INVALID) begin
            do begin
                col.code_a = t_code'($urandom_range(0, 2));
                col.code_b = t_code'($urandom_range(0, 2));
                col.code_c = t_code'($urandom_range(0, 2));
                n_hit = (col.code_a == CODE_MATCH) + (col.code_b == CODE_MATCH)
                      + (col.code_c == CODE_MATCH);
                n_ins = (col.code_a == CODE_INSERT) + (col.code_b == CODE_INSERT)
                      + (col.code_c == CODE_INSERT);
            end while (n_hit == 0 || n_ins > 1);
        end
        if ($urandom_range(0, 1)) begin
            // small alphabet so equal characters are common
            col.char_a = CHAR_IN_WIDTH'($urandom_range(0, 3));
            col.char_b = CHAR_IN_WIDTH'($urandom_range(0, 3));
            col.char_c = CHAR_IN_WIDTH'($urandom_range(0, 3));
        end else begin
            col.char_a = CHAR_IN_WIDTH'($urandom);
            col.char_b = CHAR_IN_WIDTH'($urandom);
            col.char_c = CHAR_IN_WIDTH'($urandom);
        end
        col.last_column = last;
        return col;
    endfunction

    // One alignment of len columns; noise_pct percent are arbitrary columns.
    task automatic run_alignment(input int len, input int noise_pct);
        t_column col;
        col = column_of(CODE_MATCH, CODE_MATCH, CODE_MATCH, 8'd0, 8'd0, 8'd0, 1'b0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                col.code_a      = t_code'($urandom_range(0, 3));
                col.code_b      = t_code'($urandom_range(0, 3));
                col.code_c      = t_code'($urandom_range(0, 3));
                col.char_a      = CHAR_IN_WIDTH'($urandom);
                col.char_b      = CHAR_IN_WIDTH'($urandom);
                col.char_c      = CHAR_IN_WIDTH'($urandom);
                col.last_column = 1'($urandom_range(0, 1));
                send_column(col);
                col.code_a = CODE_INVALID;  // forces fresh codes on the next legal column
            end else begin
                col = legal_column(i == len - 1, col);
                send_column(col);
            end
        end
    endtask

    function automatic logic [CFG_WIDTH-1:0] pick_cost();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 8'd1;
            2:       return '1;
            default: return CFG_WIDTH'($urandom);
        endcase
    endfunction

    // Default costs 1 / 3 / 1; directed gap code patterns and the rejected cases.
    task automatic test_directed_columns();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_column(column_of(CODE_MATCH,   CODE_MATCH,   CODE_MATCH,   8'h41, 8'h41, 8'h41, 0));
        send_column(column_of(CODE_MATCH,   CODE_MATCH,   CODE_MATCH,   8'h41, 8'h42, 8'h43, 0));
        // x-y-x pattern: one mismatch given back
        send_column(column_of(CODE_MATCH,   CODE_MATCH,   CODE_MATCH,   8'h41, 8'h42, 8'h41, 0));
        send_column(column_of(CODE_MATCH,   CODE_MATCH,   CODE_MATCH,   8'h00, 8'hFF, 8'h00, 0));
        send_column(column_of(CODE_MATCH,   CODE_MATCH,   CODE_MATCH,   8'hFF, 8'hFF, 8'h00, 0));
        // delete opens, then extends; deleted character is ignored
        send_column(column_of(CODE_DELETE,  CODE_MATCH,   CODE_MATCH,   8'hFF, 8'h20, 8'h20, 0));
        send_column(column_of(CODE_DELETE,  CODE_MATCH,   CODE_MATCH,   8'h00, 8'h20, 8'h21, 0));
        // delete turns into insert: a fresh open
        send_column(column_of(CODE_INSERT,  CODE_MATCH,   CODE_MATCH,   8'h00, 8'h01, 8'h02, 0));
        send_column(column_of(CODE_INSERT,  CODE_MATCH,   CODE_MATCH,   8'h00, 8'h01, 8'h02, 0));
        send_column(column_of(CODE_MATCH,   CODE_INSERT,  CODE_MATCH,   8'h05, 8'h09, 8'h06, 0));
        send_column(column_of(CODE_DELETE,  CODE_DELETE,  CODE_MATCH,   8'h05, 8'h09, 8'h06, 0));
        send_column(column_of(CODE_MATCH,   CODE_DELETE,  CODE_INSERT,  8'h7F, 8'h80, 8'h81, 0));
        // rejected: two inserts, no match, invalid code
        send_column(column_of(CODE_INSERT,  CODE_INSERT,  CODE_MATCH,   8'h01, 8'h02, 8'h03, 0));
        send_column(column_of(CODE_DELETE,  CODE_DELETE,  CODE_DELETE,  8'h01, 8'h02, 8'h03, 0));
        send_column(column_of(CODE_INSERT,  CODE_DELETE,  CODE_DELETE,  8'h01, 8'h02, 8'h03, 0));
        send_column(column_of(CODE_INVALID, CODE_MATCH,   CODE_MATCH,   8'h01, 8'h02, 8'h03, 0));
        send_column(column_of(CODE_MATCH,   CODE_MATCH,   CODE_INVALID, 8'h01, 8'h02, 8'h03, 0));
        send_column(column_of(CODE_MATCH,   CODE_MATCH,   CODE_MATCH,   8'hFF, 8'h00, 8'hFF, 1));
        // rejected last column still clears the alignment
        send_column(column_of(CODE_DELETE,  CODE_MATCH,   CODE_MATCH,   8'h10, 8'h11, 8'h12, 0));
        send_column(column_of(CODE_INSERT,  CODE_INSERT,  CODE_MATCH,   8'h10, 8'h11, 8'h12, 1));
        send_column(column_of(CODE_DELETE,  CODE_MATCH,   CODE_MATCH,   8'h10, 8'h11, 8'h11, 0));
        send_column(column_of(CODE_MATCH,   CODE_INSERT,  CODE_MATCH,   8'hAA, 8'h55, 8'hAA, 1));
        wait_for_scores();
    endtask

    // Each register at its extremes, zero costs, and a write to the unused index.
    task automatic test_register_extremes();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        write_reg(REG_MISMATCH, '1);
        write_reg(REG_GAP_OPEN, '1);
        write_reg(REG_GAP_EXTEND, '1);
        run_alignment(12, 0);
        run_alignment(8, 20);
        wait_for_scores();
        write_reg(REG_MISMATCH, '0);
        write_reg(REG_GAP_OPEN, '0);
        write_reg(REG_GAP_EXTEND, '0);
        write_reg(REG_UNUSED, 8'hAA);
        run_alignment(12, 10);
        wait_for_scores();
        write_reg(REG_MISMATCH, 8'd1);
        write_reg(REG_GAP_EXTEND, 8'd1);
        write_reg(REG_UNUSED, 8'h55);
        run_alignment(12, 10);
        wait_for_scores();
    endtask

    // Phases of random alignments under changing costs and handshake pacing.
    task automatic test_random_alignments();
        int phase_end;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_MISMATCH, '1);
                    write_reg(REG_GAP_OPEN, '1);
                    write_reg(REG_GAP_EXTEND, '1);
                end
                1: begin
                    write_reg(REG_MISMATCH, 8'd1);
                    write_reg(REG_GAP_OPEN, '0);
                    write_reg(REG_GAP_EXTEND, 8'd1);
                end
                default: begin
                    write_reg(REG_MISMATCH, pick_cost());
                    write_reg(REG_GAP_OPEN, pick_cost());
                    write_reg(REG_GAP_EXTEND, pick_cost());
                    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, CFG_WIDTH'($urandom));
                end
            endcase
            // pacing: both idle, sender only, sink only, none
            gaps_on  = (phase % 4 == 0) || (phase % 4 == 1);
            stall_on = (phase % 4 == 0) || (phase % 4 == 2);
            phase_end = cols_sent + 220;
            while (cols_sent < phase_end) begin
                run_alignment($urandom_range(1, 30), 15);
                // in phase 5 the sender holds off after mid-phase until the sink has caught up
                if (phase == 5 && cols_sent > phase_end - 110 && pending_scores.size() != 0)
                    wait_for_scores();
            end
            wait_for_scores();
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        col_ch.valid       = 1'b0;
        col_ch.code_a      = CODE_MATCH;
        col_ch.code_b      = CODE_MATCH;
        col_ch.code_c      = CODE_MATCH;
        col_ch.char_a      = '0;
        col_ch.char_b      = '0;
        col_ch.char_c      = '0;
        col_ch.last_column = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_MISMATCH;
        cfg_ch.data        = '0;
        res_ch.ready       = 1'b0;
        costs.mismatch_cost   = 8'd1;
        costs.gap_open_cost   = 8'd3;
        costs.gap_extend_cost = 8'd1;
        clear_alignment();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_columns();
        test_register_extremes();
        test_random_alignments();

        wait_for_scores();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_scores.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
